// File: rtl/core/bet_pkg.sv
// bet_pkg: shared types, codes and helpers for the bson element tokenizer
// no dependencies; used by bson_element_tokenizer_top
package bet_pkg;

  localparam int LENGTH_BITS = 25;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // largest length a field may carry, kept one bit wider than a length word
  localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  typedef enum logic [2:0] {
    ROLE_DOC_LEN  = 3'd0,
    ROLE_TYPE     = 3'd1,
    ROLE_KEY      = 3'd2,
    ROLE_VAL_HDR  = 3'd3,
    ROLE_VAL_DATA = 3'd4,
    ROLE_STR_END  = 3'd5,
    ROLE_DOC_END  = 3'd6,
    ROLE_DISCARD  = 3'd7
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TYPE    = 2'd1,
    ERR_LENGTH  = 2'd2,
    ERR_OVERRUN = 2'd3
  } err_t;

  localparam logic [7:0] T_DOUBLE    = 8'h01;
  localparam logic [7:0] T_STRING    = 8'h02;
  localparam logic [7:0] T_DOCUMENT  = 8'h03;
  localparam logic [7:0] T_ARRAY     = 8'h04;
  localparam logic [7:0] T_BINARY    = 8'h05;
  localparam logic [7:0] T_OBJECTID  = 8'h07;
  localparam logic [7:0] T_BOOLEAN   = 8'h08;
  localparam logic [7:0] T_DATETIME  = 8'h09;
  localparam logic [7:0] T_REGEX     = 8'h0B;
  localparam logic [7:0] T_DBPOINTER = 8'h0C;
  localparam logic [7:0] T_CODE      = 8'h0D;
  localparam logic [7:0] T_SYMBOL    = 8'h0E;
  localparam logic [7:0] T_CODE_W_S  = 8'h0F;
  localparam logic [7:0] T_INT32     = 8'h10;
  localparam logic [7:0] T_TIMESTAMP = 8'h11;
  localparam logic [7:0] T_INT64     = 8'h12;
  localparam logic [7:0] T_LAST_STD  = 8'h12;
  localparam logic [7:0] T_MAXKEY    = 8'h7F;
  localparam logic [7:0] T_MINKEY    = 8'hFF;

  function automatic logic is_known_type(input logic [7:0] t);
    return (t >= T_DOUBLE && t <= T_LAST_STD) || t == T_MAXKEY || t == T_MINKEY;
  endfunction

  function automatic logic is_string_type(input logic [7:0] t);
    return t == T_STRING || t == T_CODE || t == T_SYMBOL;
  endfunction

endpackage

// File: rtl/core/bson_element_tokenizer_top.sv
// bson_element_tokenizer_top: labels each byte of a packed bson document stream
// depends on bet_pkg for codes, length width and type helpers
//
// output: an accepted byte's labelled word is registered and shows in the next cycle
// throughput: one byte per cycle while out_ready holds; the output register takes a new word while
//   the previous one is taken in the same cycle
// reset: synchronous active-low rst_n clears parser state, the sticky error
//   and the output valid; the block expects a document length word next
module bson_element_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_byte_role,
  output logic [7:0] out_element_type,
  output logic [7:0] out_byte_out,
  output logic       out_value_part,
  output logic       out_element_last,
  output logic       out_document_last,
  output logic [1:0] out_error_code
);

  typedef enum logic [2:0] {
    PH_DOCLEN,
    PH_TYPE,
    PH_KEY,
    PH_LEN,
    PH_SUBTYPE,
    PH_BODY,
    PH_STREND,
    PH_CSTR
  } phase_t;

  typedef enum logic [1:0] {
    SUB_FIRST  = 2'd0,
    SUB_SECOND = 2'd1,
    SUB_TOTAL  = 2'd2
  } sub_t;

  phase_t        phase_r, phase_nxt;
  sub_t          sub_r, sub_nxt;
  logic [7:0]    cur_type_r, cur_type_nxt;
  bet_pkg::len_t doc_rem_r, doc_rem_nxt;
  bet_pkg::len_t piece_r, piece_nxt;
  logic [23:0]   gather_r, gather_nxt;
  logic [1:0]    lbi_r, lbi_nxt;
  bet_pkg::err_t err_r, err_nxt;

  logic          out_valid_r;
  bet_pkg::role_t role_r, role_nxt;
  logic [7:0]    etype_r, etype_nxt;
  logic [7:0]    byte_r;
  logic          part_r, part_nxt;
  logic          el_r, el_nxt;
  logic          dl_r, dl_nxt;

  logic          acc;
  logic [7:0]    b;
  logic [31:0]   len_full;
  logic          len_big;
  logic          gather_done;
  logic          fail;
  bet_pkg::err_t fail_code;
  logic [7:0]    t;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign b        = in_data_byte;

  // length word completes with the fourth byte
  assign len_full    = {b, gather_r};
  assign len_big     = {1'b0, len_full} > bet_pkg::LEN_MAX;
  assign gather_done = (lbi_r == 2'd3);

  always_comb begin
    phase_nxt    = phase_r;
    sub_nxt      = sub_r;
    cur_type_nxt = cur_type_r;
    doc_rem_nxt  = doc_rem_r;
    piece_nxt    = piece_r;
    lbi_nxt      = lbi_r;
    err_nxt      = err_r;
    gather_nxt   = gather_r;
    role_nxt     = bet_pkg::ROLE_DISCARD;
    t            = cur_type_r;
    etype_nxt    = cur_type_r;
    part_nxt     = (sub_r == SUB_SECOND);
    el_nxt       = 1'b0;
    dl_nxt       = 1'b0;
    fail         = 1'b0;
    fail_code    = bet_pkg::ERR_NONE;

    case (lbi_r)
      2'd0:    gather_nxt = {16'h0000, b};
      2'd1:    gather_nxt[15:8] = b;
      2'd2:    gather_nxt[23:16] = b;
      default: gather_nxt = gather_r;
    endcase

    if (err_r != bet_pkg::ERR_NONE) begin
      part_nxt = 1'b0;
    end else if (phase_r == PH_DOCLEN) begin
      role_nxt  = bet_pkg::ROLE_DOC_LEN;
      etype_nxt = 8'h00;
      part_nxt  = 1'b0;
      lbi_nxt   = lbi_r + 2'd1;
      if (gather_done) begin
        if (len_full < 32'd5 || len_big) begin
          fail      = 1'b1;
          fail_code = bet_pkg::ERR_LENGTH;
        end else begin
          doc_rem_nxt = len_full[bet_pkg::LENGTH_BITS-1:0] - bet_pkg::len_t'(4);
          phase_nxt   = PH_TYPE;
        end
      end
    end else if (phase_r == PH_TYPE && doc_rem_r <= bet_pkg::len_t'(1)) begin
      // terminator position of the document
      if (b != 8'h00) begin
        fail      = 1'b1;
        fail_code = bet_pkg::ERR_OVERRUN;
      end else begin
        role_nxt    = bet_pkg::ROLE_DOC_END;
        etype_nxt   = 8'h00;
        part_nxt    = 1'b0;
        dl_nxt      = 1'b1;
        doc_rem_nxt = '0;
        phase_nxt   = PH_DOCLEN;
        lbi_nxt     = 2'd0;
      end
    end else if (doc_rem_r < bet_pkg::len_t'(2)) begin
      fail      = 1'b1;
      fail_code = bet_pkg::ERR_OVERRUN;
    end else begin
      case (phase_r)
        PH_TYPE: begin
          if (b == 8'h00) begin
            fail      = 1'b1;
            fail_code = bet_pkg::ERR_OVERRUN;
          end else if (!bet_pkg::is_known_type(b)) begin
            fail      = 1'b1;
            fail_code = bet_pkg::ERR_TYPE;
          end else begin
            cur_type_nxt = b;
            t            = b;
            etype_nxt    = b;
            sub_nxt      = SUB_FIRST;
            part_nxt     = 1'b0;
            phase_nxt    = PH_KEY;
            role_nxt     = bet_pkg::ROLE_TYPE;
          end
        end
        PH_KEY: begin
          if (b != 8'h00) begin
            role_nxt = bet_pkg::ROLE_KEY;
          end else begin
            role_nxt = bet_pkg::ROLE_STR_END;
            lbi_nxt  = 2'd0;
            if (t == bet_pkg::T_DOUBLE || t == bet_pkg::T_DATETIME ||
                t == bet_pkg::T_TIMESTAMP || t == bet_pkg::T_INT64) begin
              piece_nxt = bet_pkg::len_t'(8);
              phase_nxt = PH_BODY;
            end else if (t == bet_pkg::T_INT32) begin
              piece_nxt = bet_pkg::len_t'(4);
              phase_nxt = PH_BODY;
            end else if (t == bet_pkg::T_OBJECTID) begin
              piece_nxt = bet_pkg::len_t'(12);
              phase_nxt = PH_BODY;
            end else if (t == bet_pkg::T_BOOLEAN) begin
              piece_nxt = bet_pkg::len_t'(1);
              phase_nxt = PH_BODY;
            end else if (t == bet_pkg::T_REGEX) begin
              phase_nxt = PH_CSTR;
            end else if (t == bet_pkg::T_CODE_W_S) begin
              sub_nxt   = SUB_TOTAL;
              phase_nxt = PH_LEN;
            end else if (bet_pkg::is_string_type(t) || t == bet_pkg::T_DBPOINTER ||
                         t == bet_pkg::T_DOCUMENT || t == bet_pkg::T_ARRAY ||
                         t == bet_pkg::T_BINARY) begin
              phase_nxt = PH_LEN;
            end else begin
              el_nxt = 1'b1;
            end
          end
        end
        PH_LEN: begin
          role_nxt = bet_pkg::ROLE_VAL_HDR;
          lbi_nxt  = lbi_r + 2'd1;
          if (gather_done) begin
            if (len_big) begin
              fail      = 1'b1;
              fail_code = bet_pkg::ERR_LENGTH;
            end else if (t == bet_pkg::T_CODE_W_S && sub_r == SUB_TOTAL) begin
              if (len_full < 32'd14) begin
                fail      = 1'b1;
                fail_code = bet_pkg::ERR_LENGTH;
              end else begin
                sub_nxt = SUB_FIRST;
              end
            end else if (t == bet_pkg::T_BINARY) begin
              piece_nxt = len_full[bet_pkg::LENGTH_BITS-1:0];
              phase_nxt = PH_SUBTYPE;
            end else if (t == bet_pkg::T_DOCUMENT || t == bet_pkg::T_ARRAY ||
                         (t == bet_pkg::T_CODE_W_S && sub_r == SUB_SECOND)) begin
              if (len_full < 32'd5) begin
                fail      = 1'b1;
                fail_code = bet_pkg::ERR_LENGTH;
              end else begin
                piece_nxt = len_full[bet_pkg::LENGTH_BITS-1:0] - bet_pkg::len_t'(4);
                phase_nxt = PH_BODY;
              end
            end else begin
              if (len_full == 32'd0) begin
                fail      = 1'b1;
                fail_code = bet_pkg::ERR_LENGTH;
              end else begin
                piece_nxt = len_full[bet_pkg::LENGTH_BITS-1:0] - bet_pkg::len_t'(1);
                // a length of one holds only the ending zero
                phase_nxt = (len_full == 32'd1) ? PH_STREND : PH_BODY;
              end
            end
          end
        end
        PH_SUBTYPE: begin
          role_nxt = bet_pkg::ROLE_VAL_HDR;
          if (piece_r == '0) begin
            el_nxt = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          role_nxt = bet_pkg::ROLE_VAL_DATA;
          if (piece_r > bet_pkg::len_t'(1)) begin
            piece_nxt = piece_r - bet_pkg::len_t'(1);
          end else begin
            piece_nxt = '0;
            if (bet_pkg::is_string_type(t) ||
                ((t == bet_pkg::T_DBPOINTER || t == bet_pkg::T_CODE_W_S) &&
                 sub_r == SUB_FIRST)) begin
              phase_nxt = PH_STREND;
            end else begin
              el_nxt = 1'b1;
            end
          end
        end
        PH_STREND: begin
          if (b != 8'h00) begin
            fail      = 1'b1;
            fail_code = bet_pkg::ERR_OVERRUN;
          end else begin
            role_nxt = bet_pkg::ROLE_STR_END;
            if (t == bet_pkg::T_DBPOINTER) begin
              sub_nxt   = SUB_SECOND;
              piece_nxt = bet_pkg::len_t'(12);
              phase_nxt = PH_BODY;
            end else if (t == bet_pkg::T_CODE_W_S) begin
              sub_nxt   = SUB_SECOND;
              lbi_nxt   = 2'd0;
              phase_nxt = PH_LEN;
            end else begin
              el_nxt = 1'b1;
            end
          end
        end
        default: begin
          // regex: pattern cstring then options cstring
          if (b != 8'h00) begin
            role_nxt = bet_pkg::ROLE_VAL_DATA;
          end else begin
            role_nxt = bet_pkg::ROLE_STR_END;
            if (sub_r == SUB_FIRST) begin
              sub_nxt = SUB_SECOND;
            end else begin
              el_nxt = 1'b1;
            end
          end
        end
      endcase

      doc_rem_nxt = doc_rem_r - bet_pkg::len_t'(1);
      if (el_nxt) begin
        phase_nxt = PH_TYPE;
        sub_nxt   = SUB_FIRST;
        piece_nxt = '0;
      end
    end

    // any fault discards the word and latches the code; the rest is moot
    if (fail) begin
      err_nxt   = fail_code;
      role_nxt  = bet_pkg::ROLE_DISCARD;
      etype_nxt = cur_type_r;
      part_nxt  = 1'b0;
      el_nxt    = 1'b0;
      dl_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DOCLEN;
      sub_r       <= SUB_FIRST;
      cur_type_r  <= 8'h00;
      doc_rem_r   <= '0;
      piece_r     <= '0;
      lbi_r       <= 2'd0;
      err_r       <= bet_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc || (out_valid_r && !out_ready);
      if (acc) begin
        phase_r    <= phase_nxt;
        sub_r      <= sub_nxt;
        cur_type_r <= cur_type_nxt;
        doc_rem_r  <= doc_rem_nxt;
        piece_r    <= piece_nxt;
        lbi_r      <= lbi_nxt;
        err_r      <= err_nxt;
        gather_r   <= gather_nxt;
        role_r     <= role_nxt;
        etype_r    <= etype_nxt;
        byte_r     <= b;
        part_r     <= part_nxt;
        el_r       <= el_nxt;
        dl_r       <= dl_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_role     = role_r;
  assign out_element_type  = etype_r;
  assign out_byte_out      = byte_r;
  assign out_value_part    = part_r;
  assign out_element_last  = el_r;
  assign out_document_last = dl_r;
  assign out_error_code    = err_r;

endmodule
